@@ src/akdc_pkg.sv @@
// shared types and constants for the arrow key duty controller
`timescale 1ns / 1ps

package akdc_pkg;

   // console byte codes
   localparam logic [7:0] KEY_ESC   = 8'h1b;
   localparam logic [7:0] KEY_LBR   = 8'h5b;
   localparam logic [7:0] KEY_UP    = 8'h41;
   localparam logic [7:0] KEY_DOWN  = 8'h42;
   localparam logic [7:0] KEY_RIGHT = 8'h43;
   localparam logic [7:0] KEY_LEFT  = 8'h44;
   localparam logic [7:0] KEY_SPACE = 8'h20;
   localparam logic [7:0] KEY_QUIT  = 8'h71;
   localparam logic [7:0] KEY_QUIT_UC = 8'h51;

   // register reset values, truncated to the duty or step width where used
   localparam int MIN_DUTY_RESET  = 900;
   localparam int MAX_DUTY_RESET  = 1900;
   localparam int STEP_SIZE_RESET = 5;
   localparam int STOP_DUTY_RESET = 1400;

   localparam int STEP_BITS     = 10;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [1:0] {
      REG_MIN_DUTY  = 2'd0,
      REG_MAX_DUTY  = 2'd1,
      REG_STEP_SIZE = 2'd2,
      REG_STOP_DUTY = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_UP    = 3'd1,
      ACT_DOWN  = 3'd2,
      ACT_RIGHT = 3'd3,
      ACT_LEFT  = 3'd4,
      ACT_STOP  = 3'd5,
      ACT_QUIT  = 3'd6
   } action_type;

   localparam logic [1:0] SEQ_IDLE = 2'd0;
   localparam logic [1:0] SEQ_ESC  = 2'd1;
   localparam logic [1:0] SEQ_MID  = 2'd2;

   // parser state apart from the duty itself
   typedef struct packed {
      logic [1:0] seq_count;
      logic [7:0] second_byte;
      logic       halt;
   } ctrl_type;

endpackage

@@ src/akdc_step.sv @@
// next state and action for one console byte
`timescale 1ns / 1ps

module akdc_step #(
   parameter int DUTY_BITS = 12
) (
   input  logic [7:0]                          rx_byte,
   input  akdc_pkg::ctrl_type                  ctrl_cur,
   input  logic [DUTY_BITS-1:0]                duty_cur,
   input  logic [DUTY_BITS-1:0]                min_duty,
   input  logic [DUTY_BITS-1:0]                max_duty,
   input  logic [akdc_pkg::STEP_BITS-1:0]      step_size,
   input  logic [DUTY_BITS-1:0]                stop_duty,
   output akdc_pkg::ctrl_type                  ctrl_nxt,
   output logic [DUTY_BITS-1:0]                duty_nxt,
   output akdc_pkg::action_type                action
);
   import akdc_pkg::*;

   localparam int WIDE_BITS = ((DUTY_BITS > STEP_BITS + 1) ? DUTY_BITS : STEP_BITS + 1) + 1;

   logic                 double_step;
   logic [WIDE_BITS-1:0] amount;
   logic [WIDE_BITS-1:0] sum;
   logic [WIDE_BITS-1:0] floor_cmp;
   logic [DUTY_BITS-1:0] duty_inc;
   logic [DUTY_BITS-1:0] duty_dec;

   assign double_step = (rx_byte == KEY_RIGHT) || (rx_byte == KEY_LEFT);
   assign amount = double_step ? WIDE_BITS'({step_size, 1'b0}) : WIDE_BITS'(step_size);
   assign sum       = WIDE_BITS'(duty_cur) + amount;
   assign floor_cmp = WIDE_BITS'(min_duty) + amount;

   // saturating moves, bounds applied literally even when inverted
   assign duty_inc = (sum <= WIDE_BITS'(max_duty)) ? sum[DUTY_BITS-1:0] : max_duty;
   assign duty_dec = (WIDE_BITS'(duty_cur) >= floor_cmp) ?
                     DUTY_BITS'(WIDE_BITS'(duty_cur) - amount) : min_duty;

   always_comb begin
      ctrl_nxt = ctrl_cur;
      duty_nxt = duty_cur;
      action   = ACT_NONE;
      if (!ctrl_cur.halt) begin
         priority if (rx_byte == KEY_ESC) begin
            ctrl_nxt.seq_count = SEQ_ESC;
         end else if (ctrl_cur.seq_count == SEQ_ESC) begin
            ctrl_nxt.second_byte = rx_byte;
            ctrl_nxt.seq_count   = SEQ_MID;
         end else if (ctrl_cur.seq_count != SEQ_IDLE) begin
            ctrl_nxt.seq_count = SEQ_IDLE;
            if (ctrl_cur.second_byte == KEY_LBR) begin
               unique case (rx_byte)
                  KEY_UP: begin
                     duty_nxt = duty_inc;
                     action   = ACT_UP;
                  end
                  KEY_DOWN: begin
                     duty_nxt = duty_dec;
                     action   = ACT_DOWN;
                  end
                  KEY_RIGHT: begin
                     duty_nxt = duty_inc;
                     action   = ACT_RIGHT;
                  end
                  KEY_LEFT: begin
                     duty_nxt = duty_dec;
                     action   = ACT_LEFT;
                  end
                  default: begin
                     action = ACT_NONE;
                  end
               endcase
            end
         end else if (rx_byte == KEY_QUIT || rx_byte == KEY_QUIT_UC) begin
            ctrl_nxt.halt = 1'b1;
            action        = ACT_QUIT;
         end else if (rx_byte == KEY_SPACE) begin
            duty_nxt = stop_duty;
            action   = ACT_STOP;
         end else begin
            // any other byte outside a sequence is ignored
            action = ACT_NONE;
         end
      end
   end

endmodule

@@ src/arrow_key_duty_controller.sv @@
// arrow key duty controller top level
// Parses console bytes on the req_ channel: ESC '[' A/B/C/D move a duty
// value up/down by step_size and right/left by twice step_size, saturating
// at min_duty and max_duty. Outside a sequence, space loads stop_duty and
// q or Q halts the block until reset. Every byte gives exactly one word on
// the rsp_ channel: the duty after the byte, an action code and the halt
// flag. Both channels are valid/ready.
// The accept edge loads the input register; the result register loads
// from it through the parse and saturating add/compare once it is free,
// and rsp_valid rises with it. Throughput is one byte per cycle while
// rsp_ready stays high; the duty and parser state update in the same
// cycle the result register loads.
// When the receiver stalls the result holds, the input register still
// takes one more byte, and then req_ready drops until rsp_ready returns.
// Reset clears the parser, sets the duty to 1400 and the registers to
// min 900, max 1900, step 5, stop 1400. The csr_ channel is always ready
// and should only be written while no byte is in flight.
`timescale 1ns / 1ps

module arrow_key_duty_controller #(
   parameter int DUTY_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [DUTY_BITS-1:0]                  rsp_duty_value,
   output logic [2:0]                            rsp_action_code,
   output logic                                  rsp_halted,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [1:0]                            csr_index,
   input  logic [akdc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import akdc_pkg::*;

   localparam logic [DUTY_BITS-1:0] MIN_RST  = DUTY_BITS'(MIN_DUTY_RESET);
   localparam logic [DUTY_BITS-1:0] MAX_RST  = DUTY_BITS'(MAX_DUTY_RESET);
   localparam logic [DUTY_BITS-1:0] STOP_RST = DUTY_BITS'(STOP_DUTY_RESET);
   localparam logic [STEP_BITS-1:0] STEP_RST = STEP_BITS'(STEP_SIZE_RESET);

   // configuration registers
   logic [DUTY_BITS-1:0] min_duty_ff;
   logic [DUTY_BITS-1:0] max_duty_ff;
   logic [STEP_BITS-1:0] step_size_ff;
   logic [DUTY_BITS-1:0] stop_duty_ff;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // block state
   ctrl_type             ctrl_ff;
   ctrl_type             ctrl_in;
   logic [DUTY_BITS-1:0] duty_ff, duty_in;
   action_type           action_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic [DUTY_BITS-1:0] out_duty_ff;
   logic [2:0]           out_action_ff;
   logic                 out_halt_ff;

   logic req_fire;
   logic advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_duty_ff  <= MIN_RST;
         max_duty_ff  <= MAX_RST;
         step_size_ff <= STEP_RST;
         stop_duty_ff <= STOP_RST;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_MIN_DUTY:  min_duty_ff  <= csr_wdata[DUTY_BITS-1:0];
            REG_MAX_DUTY:  max_duty_ff  <= csr_wdata[DUTY_BITS-1:0];
            REG_STEP_SIZE: step_size_ff <= csr_wdata[STEP_BITS-1:0];
            REG_STOP_DUTY: stop_duty_ff <= csr_wdata[DUTY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // the input word moves on whenever the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   akdc_step #(
      .DUTY_BITS (DUTY_BITS)
   ) u_step (
      .rx_byte   (in_byte_ff),
      .ctrl_cur  (ctrl_ff),
      .duty_cur  (duty_ff),
      .min_duty  (min_duty_ff),
      .max_duty  (max_duty_ff),
      .step_size (step_size_ff),
      .stop_duty (stop_duty_ff),
      .ctrl_nxt  (ctrl_in),
      .duty_nxt  (duty_in),
      .action    (action_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctrl_ff      <= '0;
         duty_ff      <= STOP_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            ctrl_ff <= ctrl_in;
            duty_ff <= duty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_duty_ff   <= duty_in;
         out_action_ff <= action_in;
         out_halt_ff   <= ctrl_in.halt;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_duty_value  = out_duty_ff;
   assign rsp_action_code = out_action_ff;
   assign rsp_halted      = out_halt_ff;

   // once halted, the block stays halted with a frozen duty
   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.halt |=> ctrl_ff.halt)
      else $error("halt flag cleared without reset");

   a_halt_frozen : assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.halt |=> $stable(duty_ff))
      else $error("duty changed while halted");

   a_quit_halts : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_action_ff == ACT_QUIT) |-> out_halt_ff)
      else $error("quit word without halt flag");

   a_seq_range : assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.seq_count != 2'd3)
      else $error("sequence counter out of range");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> $stable(out_duty_ff) && $stable(out_action_ff))
      else $error("result overwritten while stalled");

endmodule

@@ tb/sv/arrow_key_duty_controller_tb.sv @@
// self-checking testbench for the arrow key duty controller
`timescale 1ns / 1ps

module arrow_key_duty_controller_tb;
   import akdc_pkg::*;

   localparam int DUTY_W = 12;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      action_type        action;
      logic              halted;
   } duty_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_rx_byte = 8'h00;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [DUTY_W-1:0]        rsp_duty_value;
   logic [2:0]               rsp_action_code;
   logic                     rsp_halted;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [1:0]               csr_index = 2'd0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // predicted block state
   logic [1:0]          m_seq;
   logic [7:0]          m_second;
   logic [DUTY_W-1:0]   m_duty;
   logic                m_halt;
   logic [DUTY_W-1:0]   m_min;
   logic [DUTY_W-1:0]   m_max;
   logic [STEP_BITS-1:0] m_step;
   logic [DUTY_W-1:0]   m_stop;

   duty_word_type duty_word_q[$];
   int         errors = 0;
   int         bytes_sent = 0;
   bit         tx_gaps_on = 1'b1;
   bit         rsp_stall_on = 1'b1;
   int         rsp_hold = 0;

   arrow_key_duty_controller #(.DUTY_BITS(DUTY_W)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_duty_value  (rsp_duty_value),
      .rsp_action_code (rsp_action_code),
      .rsp_halted      (rsp_halted),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [DUTY_W-1:0] sat_up(input logic [DUTY_W-1:0] d,
                                                input int unsigned s);
      int unsigned sum;
      sum = d + s;
      return (sum <= m_max) ? sum[DUTY_W-1:0] : m_max;
   endfunction

   function automatic logic [DUTY_W-1:0] sat_down(input logic [DUTY_W-1:0] d,
                                                  input int unsigned s);
      int unsigned floor_val;
      floor_val = m_min + s;
      return (d >= floor_val) ? DUTY_W'(d - s) : m_min;
   endfunction

   function automatic duty_word_type predict_byte(input logic [7:0] b);
      duty_word_type w;
      action_type  act;
      int unsigned step1;
      act = ACT_NONE;
      step1 = m_step;
      if (!m_halt) begin
         if (b == KEY_ESC) begin
            m_seq = SEQ_ESC;
         end else if (m_seq == SEQ_ESC) begin
            m_second = b;
            m_seq = SEQ_MID;
         end else if (m_seq != SEQ_IDLE) begin
            // final byte only counts after a bracket
            if (m_second == KEY_LBR) begin
               case (b)
                  KEY_UP: begin
                     m_duty = sat_up(m_duty, step1);
                     act = ACT_UP;
                  end
                  KEY_DOWN: begin
                     m_duty = sat_down(m_duty, step1);
                     act = ACT_DOWN;
                  end
                  KEY_RIGHT: begin
                     m_duty = sat_up(m_duty, step1 * 2);
                     act = ACT_RIGHT;
                  end
                  KEY_LEFT: begin
                     m_duty = sat_down(m_duty, step1 * 2);
                     act = ACT_LEFT;
                  end
                  default: act = ACT_NONE;
               endcase
            end
            m_seq = SEQ_IDLE;
         end else if (b == KEY_QUIT || b == KEY_QUIT_UC) begin
            m_halt = 1'b1;
            act = ACT_QUIT;
         end else if (b == KEY_SPACE) begin
            m_duty = m_stop;
            act = ACT_STOP;
         end
      end
      w.duty = m_duty;
      w.action = act;
      w.halted = m_halt;
      return w;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // random traffic must not halt the block before the quit test
   function automatic logic [7:0] keep_alive(input logic [7:0] b);
      if (m_seq == SEQ_IDLE && (b == KEY_QUIT || b == KEY_QUIT_UC)) return b ^ 8'h01;
      return b;
   endfunction

   function automatic logic [7:0] pick_arrow(input int bias);
      int r;
      bit up;
      r = $urandom_range(0, 9);
      case (bias)
         1:       up = (r < 8);
         2:       up = (r < 2);
         default: up = (r < 5);
      endcase
      if (up) return $urandom_range(0, 1) ? KEY_UP : KEY_RIGHT;
      return $urandom_range(0, 1) ? KEY_DOWN : KEY_LEFT;
   endfunction

   function automatic logic [7:0] pick_cmd();
      case ($urandom_range(0, 3))
         0:       return KEY_SPACE;
         1:       return KEY_QUIT;
         2:       return KEY_QUIT_UC;
         default: return KEY_LBR;
      endcase
   endfunction

   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= idle_len();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   duty_word_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (duty_word_q.size() == 0) begin
            $display("%0t unexpected word: duty %0d action %0d halted %0d", $time,
                     rsp_duty_value, rsp_action_code, rsp_halted);
            errors++;
         end else begin
            want = duty_word_q.pop_front();
            if (rsp_duty_value !== want.duty) begin
               $display("%0t duty mismatch: expected %0d actual %0d", $time,
                        want.duty, rsp_duty_value);
               errors++;
            end
            if (rsp_action_code !== want.action) begin
               $display("%0t action mismatch: expected %0d actual %0d", $time,
                        want.action, rsp_action_code);
               errors++;
            end
            if (rsp_halted !== want.halted) begin
               $display("%0t halted mismatch: expected %0d actual %0d", $time,
                        want.halted, rsp_halted);
               errors++;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = tx_gaps_on ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      duty_word_q.push_back(predict_byte(b));
      bytes_sent++;
   endtask

   // sender holds off until every word has come back
   task automatic wait_idle();
      int spin;
      spin = 0;
      req_valid <= 1'b0;
      while (duty_word_q.size() != 0 && spin < 20000) begin
         @(posedge clock);
         spin++;
      end
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need no second assignment
   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      logic [CSR_DATA_BITS-1:0] data;
      data = CSR_DATA_BITS'($urandom);
      if (idx == REG_STEP_SIZE) data[STEP_BITS-1:0] = value[STEP_BITS-1:0];
      else data[DUTY_W-1:0] = value[DUTY_W-1:0];
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_MIN_DUTY:  m_min  = data[DUTY_W-1:0];
         REG_MAX_DUTY:  m_max  = data[DUTY_W-1:0];
         REG_STEP_SIZE: m_step = data[STEP_BITS-1:0];
         REG_STOP_DUTY: m_stop = data[DUTY_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input int lo, input int hi, input int step, input int stop);
      write_reg(REG_MIN_DUTY, 16'(lo));
      write_reg(REG_MAX_DUTY, 16'(hi));
      write_reg(REG_STEP_SIZE, 16'(step));
      write_reg(REG_STOP_DUTY, 16'(stop));
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_values();
      send_byte(8'h00);
      send_byte(8'hff);
   endtask

   task automatic test_arrow_keys();
      send_byte(KEY_ESC); send_byte(KEY_LBR); send_byte(KEY_UP);
      send_byte(KEY_ESC); send_byte(KEY_LBR); send_byte(KEY_DOWN);
      send_byte(KEY_ESC); send_byte(KEY_LBR); send_byte(KEY_RIGHT);
      send_byte(KEY_ESC); send_byte(KEY_LBR); send_byte(KEY_LEFT);
      send_byte(KEY_SPACE);
   endtask

   task automatic test_broken_sequences();
      // esc restarts a sequence already under way
      send_byte(KEY_ESC); send_byte(KEY_ESC); send_byte(KEY_LBR); send_byte(KEY_RIGHT);
      // second byte not a bracket, and a quit key taken as sequence data
      send_byte(KEY_ESC); send_byte(KEY_QUIT); send_byte(KEY_UP);
      // unknown final byte
      send_byte(KEY_ESC); send_byte(KEY_LBR); send_byte(KEY_QUIT_UC);
   endtask

   task automatic send_console_traffic(input int count, input int bias);
      int start;
      int r;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            send_byte(KEY_ESC); send_byte(KEY_LBR); send_byte(pick_arrow(bias));
         end else if (r < 67) begin
            send_byte(KEY_ESC);
            send_byte(keep_alive(8'($urandom)));
            send_byte(keep_alive(8'($urandom)));
         end else if (r < 74) begin
            send_byte(KEY_ESC); send_byte(KEY_LBR); send_byte(keep_alive(8'($urandom)));
         end else if (r < 81) begin
            send_byte(KEY_SPACE);
         end else if (r < 90) begin
            send_byte(keep_alive(8'($urandom)));
         end else if (r < 95) begin
            send_byte(KEY_ESC);
            if ($urandom_range(0, 1)) send_byte(KEY_LBR);
            send_byte(KEY_ESC); send_byte(KEY_LBR); send_byte(pick_arrow(bias));
         end else begin
            send_byte(KEY_ESC); send_byte(pick_cmd()); send_byte(pick_cmd());
         end
      end
   endtask

   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < 9; phase++) begin
         wait_idle();
         tx_gaps_on = (phase % 3 != 0);
         rsp_stall_on = (phase % 3 != 0) || (phase == 6);
         case (phase)
            0: load_settings(MIN_DUTY_RESET, MAX_DUTY_RESET, STEP_SIZE_RESET, STOP_DUTY_RESET);
            1: load_settings(0, 4095, 1023, 0);
            2: load_settings(4095, 0, 1023, 4095);      // inverted bounds
            3: load_settings(2000, 2000, 0, 2000);
            4: load_settings(100, 300, 1, 4095);        // stop duty above max
            default: load_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 1) ? $urandom_range(0, 40)
                                                        : $urandom_range(0, 1023),
                                   $urandom_range(0, 4095));
         endcase
         send_console_traffic(200, $urandom_range(0, 2));
      end
      tx_gaps_on = 1'b1;
      rsp_stall_on = 1'b1;
   endtask

   task automatic test_quit();
      logic [7:0] quit_key;
      logic [7:0] other_key;
      quit_key = $urandom_range(0, 1) ? KEY_QUIT : KEY_QUIT_UC;
      other_key = (quit_key == KEY_QUIT) ? KEY_QUIT_UC : KEY_QUIT;
      send_byte(KEY_ESC); send_byte(KEY_LBR); send_byte(KEY_UP);
      send_byte(quit_key);
      // halted: everything below is ignored
      send_byte(KEY_ESC); send_byte(KEY_LBR); send_byte(KEY_UP);
      send_byte(KEY_SPACE);
      send_byte(other_key);
      send_byte(8'hff);
      send_byte(8'($urandom));
   endtask

   initial begin
      m_seq    = SEQ_IDLE;
      m_second = 8'h00;
      m_duty   = DUTY_W'(STOP_DUTY_RESET);
      m_halt   = 1'b0;
      m_min    = DUTY_W'(MIN_DUTY_RESET);
      m_max    = DUTY_W'(MAX_DUTY_RESET);
      m_step   = STEP_BITS'(STEP_SIZE_RESET);
      m_stop   = DUTY_W'(STOP_DUTY_RESET);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_arrow_keys();
      test_broken_sequences();
      test_random_traffic();
      test_quit();
      wait_idle();
      repeat (8) @(posedge clock);
      if (duty_word_q.size() != 0) begin
         $display("%0t %0d expected words never arrived", $time, duty_word_q.size());
         errors += duty_word_q.size();
      end
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/akdc_pkg.sv
src/akdc_step.sv
src/arrow_key_duty_controller.sv
tb/sv/arrow_key_duty_controller_tb.sv
